FILE: rtl/csig_pkg.sv
package csig_pkg;

  localparam int IN_W       = 24;
  localparam int TOT_W      = 34;
  localparam int SQ_W       = 58;
  localparam int OUT_W      = 32;
  localparam int NUM_W      = 76;
  localparam int DEN_W      = 38;
  localparam int Z_W        = 44;
  localparam int A_W        = 39;
  localparam int ROOT_W     = 32;
  localparam int R_W        = 30;
  localparam int CNT_W      = 7;

  localparam logic [CNT_W-1:0] DIV_CNT_Z = 7'd57;
  localparam logic [CNT_W-1:0] DIV_CNT_A = 7'd52;
  localparam logic [CNT_W-1:0] DIV_CNT_C = 7'd32;

  localparam logic CFG_IDX_MODE = 1'b0;

  typedef enum logic [4:0] {
    S_IDLE, S_SQUARE, S_ACC, S_CHECK,
    S_R_GO, S_R_WAIT, S_Z_GO, S_Z_WAIT,
    S_QS_GO, S_QS_WAIT, S_A_GO, S_A_WAIT,
    S_QB_GO, S_QB_WAIT, S_MUL, S_PADD,
    S_C_GO, S_C_WAIT, S_HMUL, S_HADD,
    S_E_GO, S_E_WAIT, S_FIN
  } csig_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SQUARE, OP_ACC,
    OP_R_GO, OP_R_WAIT, OP_Z_GO, OP_Z_WAIT,
    OP_QS_GO, OP_QS_WAIT, OP_A_GO, OP_A_WAIT,
    OP_QB_GO, OP_QB_WAIT, OP_MUL, OP_PADD,
    OP_C_GO, OP_C_WAIT, OP_HMUL, OP_HADD,
    OP_E_GO, OP_E_WAIT, OP_PUBLISH
  } csig_op_t;

  typedef struct packed {
    csig_op_t op;
  } csig_cmd_t;

  typedef struct packed {
    logic b_zero;
    logic sqrt_idle;
    logic div_idle;
  } csig_stat_t;

endpackage

FILE: rtl/csig_bin_if.sv
interface csig_bin_if;
  logic        valid;
  logic        ready;
  logic        first_bin;
  logic [23:0] signal_count;
  logic [23:0] signal_error;
  logic [23:0] background_count;
  logic [23:0] background_error;

  modport source (output valid, first_bin, signal_count, signal_error,
                  background_count, background_error, input ready);
  modport sink (input valid, first_bin, signal_count, signal_error,
                background_count, background_error, output ready);
endinterface

FILE: rtl/csig_res_if.sv
interface csig_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] significance;
  logic [31:0] significance_error;
  logic        no_background;

  modport source (output valid, significance, significance_error, no_background,
                  input ready);
  modport sink (input valid, significance, significance_error, no_background,
                output ready);
endinterface

FILE: rtl/csig_sqrt.sv
module csig_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        idle,
  output logic [31:0] root
);

  logic        busy;
  logic [4:0]  k;
  logic [63:0] rem_n;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [63:0] trial;
  logic        ge;

  assign bitv  = 64'd1 << {k, 1'b0};
  assign trial = res + bitv;
  assign ge    = rem_n >= trial;
  assign idle  = !busy;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && k == 5'd0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_n <= radicand;
      res   <= '0;
      k     <= 5'd31;
    end else if (busy) begin
      if (ge) begin
        rem_n <= rem_n - trial;
        res   <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      k <= k - 5'd1;
    end
  end

endmodule

FILE: rtl/csig_div.sv
module csig_div (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [csig_pkg::NUM_W-1:0]             num,
  input  logic [csig_pkg::DEN_W-1:0]             rem_init,
  input  logic [csig_pkg::DEN_W-1:0]             den,
  input  logic [csig_pkg::CNT_W-1:0]             count,
  output logic                                   idle,
  output logic [csig_pkg::NUM_W-1:0]             quo
);

  logic                          busy;
  logic [csig_pkg::CNT_W-1:0]    cnt;
  logic [csig_pkg::DEN_W-1:0]    rem;
  logic [csig_pkg::DEN_W-1:0]    den_r;
  logic [csig_pkg::NUM_W-1:0]    numq;
  logic [csig_pkg::DEN_W:0]      rem_sh;
  logic [csig_pkg::DEN_W:0]      diff;
  logic                          ge;

  assign rem_sh = {rem, numq[csig_pkg::NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign idle   = !busy;
  assign quo    = numq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= count;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= rem_init;
      den_r <= den;
      numq  <= num;
    end else if (busy) begin
      rem  <= ge ? diff[csig_pkg::DEN_W-1:0] : rem_sh[csig_pkg::DEN_W-1:0];
      numq <= {numq[csig_pkg::NUM_W-2:0], ge};
    end
  end

endmodule

FILE: rtl/csig_ctrl.sv
module csig_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  csig_pkg::csig_stat_t  stat,
  output csig_pkg::csig_cmd_t   cmd
);

  csig_pkg::csig_state_t state, state_next;
  logic                  publish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= csig_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      csig_pkg::S_IDLE:    if (in_valid) state_next = csig_pkg::S_SQUARE;
      csig_pkg::S_SQUARE:  state_next = csig_pkg::S_ACC;
      csig_pkg::S_ACC:     state_next = csig_pkg::S_CHECK;
      csig_pkg::S_CHECK: begin
        state_next = stat.b_zero ? csig_pkg::S_FIN : csig_pkg::S_R_GO;
      end
      csig_pkg::S_R_GO:    state_next = csig_pkg::S_R_WAIT;
      csig_pkg::S_R_WAIT:  if (stat.sqrt_idle) state_next = csig_pkg::S_Z_GO;
      csig_pkg::S_Z_GO:    state_next = csig_pkg::S_Z_WAIT;
      csig_pkg::S_Z_WAIT:  if (stat.div_idle) state_next = csig_pkg::S_QS_GO;
      csig_pkg::S_QS_GO:   state_next = csig_pkg::S_QS_WAIT;
      csig_pkg::S_QS_WAIT: if (stat.sqrt_idle) state_next = csig_pkg::S_A_GO;
      csig_pkg::S_A_GO:    state_next = csig_pkg::S_A_WAIT;
      csig_pkg::S_A_WAIT:  if (stat.div_idle) state_next = csig_pkg::S_QB_GO;
      csig_pkg::S_QB_GO:   state_next = csig_pkg::S_QB_WAIT;
      csig_pkg::S_QB_WAIT: if (stat.sqrt_idle) state_next = csig_pkg::S_MUL;
      csig_pkg::S_MUL:     state_next = csig_pkg::S_PADD;
      csig_pkg::S_PADD:    state_next = csig_pkg::S_C_GO;
      csig_pkg::S_C_GO:    state_next = csig_pkg::S_C_WAIT;
      csig_pkg::S_C_WAIT:  if (stat.div_idle) state_next = csig_pkg::S_HMUL;
      csig_pkg::S_HMUL:    state_next = csig_pkg::S_HADD;
      csig_pkg::S_HADD:    state_next = csig_pkg::S_E_GO;
      csig_pkg::S_E_GO:    state_next = csig_pkg::S_E_WAIT;
      csig_pkg::S_E_WAIT:  if (stat.sqrt_idle) state_next = csig_pkg::S_FIN;
      csig_pkg::S_FIN:     if (!out_valid || out_ready) state_next = csig_pkg::S_IDLE;
      default:             state_next = csig_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    publish  = 1'b0;
    cmd.op   = csig_pkg::OP_NONE;
    case (state)
      csig_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = csig_pkg::OP_LOAD;
      end
      csig_pkg::S_SQUARE:  cmd.op = csig_pkg::OP_SQUARE;
      csig_pkg::S_ACC:     cmd.op = csig_pkg::OP_ACC;
      csig_pkg::S_CHECK:   cmd.op = csig_pkg::OP_NONE;
      csig_pkg::S_R_GO:    cmd.op = csig_pkg::OP_R_GO;
      csig_pkg::S_R_WAIT:  cmd.op = csig_pkg::OP_R_WAIT;
      csig_pkg::S_Z_GO:    cmd.op = csig_pkg::OP_Z_GO;
      csig_pkg::S_Z_WAIT:  cmd.op = csig_pkg::OP_Z_WAIT;
      csig_pkg::S_QS_GO:   cmd.op = csig_pkg::OP_QS_GO;
      csig_pkg::S_QS_WAIT: cmd.op = csig_pkg::OP_QS_WAIT;
      csig_pkg::S_A_GO:    cmd.op = csig_pkg::OP_A_GO;
      csig_pkg::S_A_WAIT:  cmd.op = csig_pkg::OP_A_WAIT;
      csig_pkg::S_QB_GO:   cmd.op = csig_pkg::OP_QB_GO;
      csig_pkg::S_QB_WAIT: cmd.op = csig_pkg::OP_QB_WAIT;
      csig_pkg::S_MUL:     cmd.op = csig_pkg::OP_MUL;
      csig_pkg::S_PADD:    cmd.op = csig_pkg::OP_PADD;
      csig_pkg::S_C_GO:    cmd.op = csig_pkg::OP_C_GO;
      csig_pkg::S_C_WAIT:  cmd.op = csig_pkg::OP_C_WAIT;
      csig_pkg::S_HMUL:    cmd.op = csig_pkg::OP_HMUL;
      csig_pkg::S_HADD:    cmd.op = csig_pkg::OP_HADD;
      csig_pkg::S_E_GO:    cmd.op = csig_pkg::OP_E_GO;
      csig_pkg::S_E_WAIT:  cmd.op = csig_pkg::OP_E_WAIT;
      csig_pkg::S_FIN: begin
        if (!out_valid || out_ready) begin
          publish = 1'b1;
          cmd.op  = csig_pkg::OP_PUBLISH;
        end
      end
      default: cmd.op = csig_pkg::OP_NONE;
    endcase
  end

endmodule

FILE: rtl/csig_dp.sv
module csig_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  mode,
  input  csig_pkg::csig_cmd_t   cmd,
  input  logic                  first_bin,
  input  logic [23:0]           signal_count,
  input  logic [23:0]           signal_error,
  input  logic [23:0]           background_count,
  input  logic [23:0]           background_error,
  output csig_pkg::csig_stat_t  stat,
  output logic [31:0]           significance,
  output logic [31:0]           significance_error,
  output logic                  no_background
);

  logic                          first_r;
  logic [csig_pkg::IN_W-1:0]     sc, se, bc, be;
  logic [2*csig_pkg::IN_W-1:0]   se2, be2;
  logic [csig_pkg::TOT_W-1:0]    s_tot, b_tot, s_op, b_op;
  logic [csig_pkg::SQ_W-1:0]     es_tot, eb_tot, es_op, eb_op;
  logic [csig_pkg::TOT_W-1:0]    s_tot_next, b_tot_next;
  logic [csig_pkg::SQ_W-1:0]     es_tot_next, eb_tot_next;
  logic [csig_pkg::TOT_W-1:0]    s_base, b_base;
  logic [csig_pkg::SQ_W-1:0]     es_base, eb_base;
  logic [csig_pkg::TOT_W:0]      s_sum, b_sum;
  logic [csig_pkg::SQ_W:0]       es_sum, eb_sum;

  logic [csig_pkg::R_W-1:0]      r;
  logic [csig_pkg::Z_W-1:0]      z;
  logic [csig_pkg::ROOT_W-1:0]   qs, qb, c, e;
  logic [csig_pkg::A_W-1:0]      a;
  logic [63:0]                   p_lo;
  logic [43:0]                   p_hi;
  logic [csig_pkg::NUM_W-1:0]    p;
  logic                          c_ovf, e_max;
  logic [63:0]                   a2, c2;
  logic [64:0]                   hsum;
  logic                          b_zero;

  logic                          sqrt_start, sqrt_idle;
  logic [63:0]                   radicand;
  logic [csig_pkg::ROOT_W-1:0]   root;
  logic                          div_start, div_idle;
  logic [csig_pkg::NUM_W-1:0]    num, quo;
  logic [csig_pkg::DEN_W-1:0]    den, rem_init;
  logic [csig_pkg::CNT_W-1:0]    count;

  assign b_zero      = (b_op == '0);
  assign stat.b_zero    = b_zero;
  assign stat.sqrt_idle = sqrt_idle;
  assign stat.div_idle  = div_idle;

  assign s_base  = first_r ? '0 : s_tot;
  assign b_base  = first_r ? '0 : b_tot;
  assign es_base = first_r ? '0 : es_tot;
  assign eb_base = first_r ? '0 : eb_tot;
  assign s_sum   = {1'b0, s_base} + {11'd0, sc};
  assign b_sum   = {1'b0, b_base} + {11'd0, bc};
  assign es_sum  = {1'b0, es_base} + {11'd0, se2};
  assign eb_sum  = {1'b0, eb_base} + {11'd0, be2};
  assign s_tot_next  = s_sum[csig_pkg::TOT_W] ? '1 : s_sum[csig_pkg::TOT_W-1:0];
  assign b_tot_next  = b_sum[csig_pkg::TOT_W] ? '1 : b_sum[csig_pkg::TOT_W-1:0];
  assign es_tot_next = es_sum[csig_pkg::SQ_W] ? '1 : es_sum[csig_pkg::SQ_W-1:0];
  assign eb_tot_next = eb_sum[csig_pkg::SQ_W] ? '1 : eb_sum[csig_pkg::SQ_W-1:0];

  always_comb begin
    sqrt_start = 1'b0;
    radicand   = hsum[63:0];
    case (cmd.op)
      csig_pkg::OP_R_GO: begin
        sqrt_start = 1'b1;
        radicand   = {4'd0, b_op, 26'd0};
      end
      csig_pkg::OP_QS_GO: begin
        sqrt_start = 1'b1;
        radicand   = {es_op, 6'd0};
      end
      csig_pkg::OP_QB_GO: begin
        sqrt_start = 1'b1;
        radicand   = {eb_op, 6'd0};
      end
      csig_pkg::OP_E_GO: begin
        sqrt_start = 1'b1;
        radicand   = hsum[63:0];
      end
      default: sqrt_start = 1'b0;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    num       = {s_op, 42'd0};
    den       = {8'd0, r};
    rem_init  = '0;
    count     = csig_pkg::DIV_CNT_Z;
    case (cmd.op)
      csig_pkg::OP_Z_GO: begin
        div_start = 1'b1;
      end
      csig_pkg::OP_A_GO: begin
        div_start = 1'b1;
        num       = {qs, 44'd0};
        count     = csig_pkg::DIV_CNT_A;
      end
      csig_pkg::OP_C_GO: begin
        div_start = 1'b1;
        num       = {p[31:0], 44'd0};
        den       = {b_op, 4'd0};
        rem_init  = p[69:32];
        count     = csig_pkg::DIV_CNT_C;
      end
      default: div_start = 1'b0;
    endcase
  end

  csig_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (radicand),
    .idle     (sqrt_idle),
    .root     (root)
  );

  csig_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (num),
    .rem_init (rem_init),
    .den      (den),
    .count    (count),
    .idle     (div_idle),
    .quo      (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s_tot  <= '0;
      b_tot  <= '0;
      es_tot <= '0;
      eb_tot <= '0;
    end else if (cmd.op == csig_pkg::OP_ACC && mode) begin
      s_tot  <= s_tot_next;
      b_tot  <= b_tot_next;
      es_tot <= es_tot_next;
      eb_tot <= eb_tot_next;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      csig_pkg::OP_LOAD: begin
        first_r <= first_bin;
        sc      <= signal_count;
        se      <= signal_error;
        bc      <= background_count;
        be      <= background_error;
      end
      csig_pkg::OP_SQUARE: begin
        se2 <= se * se;
        be2 <= be * be;
      end
      csig_pkg::OP_ACC: begin
        if (mode) begin
          s_op  <= s_tot_next;
          b_op  <= b_tot_next;
          es_op <= es_tot_next;
          eb_op <= eb_tot_next;
        end else begin
          s_op  <= {10'd0, sc};
          b_op  <= {10'd0, bc};
          es_op <= {10'd0, se2};
          eb_op <= {10'd0, be2};
        end
      end
      csig_pkg::OP_R_WAIT:  r  <= root[csig_pkg::R_W-1:0];
      csig_pkg::OP_Z_WAIT:  z  <= quo[csig_pkg::Z_W-1:0];
      csig_pkg::OP_QS_WAIT: qs <= root;
      csig_pkg::OP_A_WAIT:  a  <= quo[csig_pkg::A_W-1:0];
      csig_pkg::OP_QB_WAIT: qb <= root;
      csig_pkg::OP_MUL: begin
        p_lo <= z[31:0] * qb;
        p_hi <= z[43:32] * qb;
      end
      csig_pkg::OP_PADD: p <= {p_hi, 32'd0} + {12'd0, p_lo};
      csig_pkg::OP_C_GO: c_ovf <= p[75:32] >= {6'd0, b_op, 4'd0};
      csig_pkg::OP_C_WAIT: c <= quo[31:0];
      csig_pkg::OP_HMUL: begin
        a2    <= a[31:0] * a[31:0];
        c2    <= c * c;
        e_max <= c_ovf || (a[38:32] != '0);
      end
      csig_pkg::OP_HADD:   hsum <= {1'b0, a2} + {1'b0, c2};
      csig_pkg::OP_E_WAIT: e    <= root;
      csig_pkg::OP_PUBLISH: begin
        no_background <= b_zero;
        if (b_zero) begin
          significance       <= '0;
          significance_error <= '0;
        end else begin
          significance       <= (z[43:32] != '0) ? '1 : z[31:0];
          significance_error <= (e_max || hsum[64]) ? '1 : e;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/cumulative_significance_engine.sv
// channel    dir  payload
// bin_in     in   first_bin, signal_count, signal_error, background_count,
//                 background_error
// res_out    out  significance, significance_error, no_background
// apb        in   cumulative_mode at byte address 0
//
// Between one accept and the next, a word runs four roots on one shared
// square-root unit (32 steps each), three divides on one shared radix-2
// divider (57, 52, 32 steps), and the load, square, accumulate, check,
// multiply, add and finish states.
// A word with zero background skips the roots and divides.
// rst is synchronous; it clears the running sums and sets cumulative_mode.
// A finished word waits in the output register; the next bin is taken
// meanwhile, and a further result holds until res_out drains.
module cumulative_significance_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  csig_bin_if.sink           bin_in,
  csig_res_if.source         res_out
);

  logic                  mode;
  csig_pkg::csig_cmd_t   cmd;
  csig_pkg::csig_stat_t  stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == csig_pkg::CFG_IDX_MODE) ? {31'd0, mode} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == csig_pkg::CFG_IDX_MODE) begin
      mode <= pwdata[0];
    end
  end

  csig_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (bin_in.valid),
    .in_ready  (bin_in.ready),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  csig_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .mode               (mode),
    .cmd                (cmd),
    .first_bin          (bin_in.first_bin),
    .signal_count       (bin_in.signal_count),
    .signal_error       (bin_in.signal_error),
    .background_count   (bin_in.background_count),
    .background_error   (bin_in.background_error),
    .stat               (stat),
    .significance       (res_out.significance),
    .significance_error (res_out.significance_error),
    .no_background      (res_out.no_background)
  );

endmodule
